@@ rtl/annb_pkg.sv @@
package annb_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int FIELD_W         = 24;
	localparam int MAX_RESULTS     = 5;
	localparam int DELAY_DEPTH     = 4;

	localparam logic [4:0] TYPE_MASK = 5'h1F;
	localparam logic [4:0] TYPE_SPS  = 5'd7;
	localparam logic [4:0] TYPE_PPS  = 5'd8;
	localparam logic [4:0] TYPE_AUD  = 5'd9;

	localparam logic [7:0] CODE_ONE  = 8'h01;
	localparam int         TAG_HDR   = 4;
	localparam int         BODY_BASE = 5;

	// Everything one input byte produces; the output stage derives the
	// per-result fields from the result index.
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [2:0]                  count;
		logic                        has_bytes;
		logic                        first;
		logic                        close;
		logic                        frame;
		logic                        no_code;
		logic                        keep;
		logic [4:0]                  ntype;
		logic [FIELD_W-1:0]          nlen;
		logic [FIELD_W-1:0]          body;
	} batch_t;

	function automatic logic is_kept(input logic [4:0] t);
		is_kept = !(t == TYPE_SPS || t == TYPE_PPS || t == TYPE_AUD);
	endfunction

endpackage

@@ rtl/annb_byte_if.sv @@
interface annb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;

	modport source(output valid, data_byte, frame_last, input ready);
	modport sink(input valid, data_byte, frame_last, output ready);
endinterface

@@ rtl/annb_nalu_if.sv @@
interface annb_nalu_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic [4:0]  unit_type;
	logic        nalu_first;
	logic        nalu_last;
	logic        nalu_keep;
	logic [23:0] nalu_length;
	logic        frame_done;
	logic [23:0] body_length;
	logic        no_start_code;
	logic        run_last;

	modport source(output valid, out_byte, byte_valid, unit_type, nalu_first, nalu_last,
		nalu_keep, nalu_length, frame_done, body_length, no_start_code, run_last,
		input ready);
	modport sink(input valid, out_byte, byte_valid, unit_type, nalu_first, nalu_last,
		nalu_keep, nalu_length, frame_done, body_length, no_start_code, run_last,
		output ready);
endinterface

@@ rtl/annb_parse.sv @@
module annb_parse #(
	parameter int LENGTH_BITS = annb_pkg::LENGTH_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                frame_last,
	output annb_pkg::batch_t    batch
);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	logic [7:0]             delay_q [annb_pkg::DELAY_DEPTH];
	logic [2:0]             dcnt_q;
	logic                   seen_q;
	logic                   at_start_q;
	logic [4:0]             type_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [LENGTH_BITS-1:0] run_q;

	logic [7:0]             nd [annb_pkg::DELAY_DEPTH];
	logic [2:0]             ncnt;
	logic [3:0]             zero;
	logic                   sc;
	logic                   code4;
	logic [2:0]             pay;
	logic [2:0]             a_n;
	logic [2:0]             b_n;
	logic [2:0]             n;
	logic                   seen_n;
	logic                   first;
	logic                   close;
	logic [4:0]             ntype;
	logic                   keep;
	logic [LENGTH_BITS:0]   len_sum;
	logic [LENGTH_BITS-1:0] len_res;
	logic [LENGTH_BITS:0]   tag_sum;
	logic [LENGTH_BITS-1:0] tag_len;
	logic [LENGTH_BITS:0]   body_sum;
	logic [LENGTH_BITS-1:0] body_sat;
	logic [LENGTH_BITS-1:0] run_n;
	logic [31:0]            len_ext;
	logic [31:0]            body_ext;

	always_comb begin
		for (int i = 0; i < annb_pkg::DELAY_DEPTH; i++) begin
			zero[i] = (delay_q[i] == 8'd0);
		end

		// start code detection against the bytes held in the delay line
		sc    = 1'b0;
		code4 = 1'b0;
		pay   = 3'd0;
		case (dcnt_q)
			3'd2: begin
				sc = (data_byte == annb_pkg::CODE_ONE) && zero[0] && zero[1];
			end
			3'd3: begin
				sc    = (data_byte == annb_pkg::CODE_ONE) && zero[1] && zero[2];
				code4 = zero[0];
				pay   = code4 ? 3'd0 : 3'd1;
			end
			3'd4: begin
				sc    = (data_byte == annb_pkg::CODE_ONE) && zero[2] && zero[3];
				code4 = zero[1];
				pay   = code4 ? 3'd1 : 3'd2;
			end
			default: begin
			end
		endcase

		nd = delay_q;
		if (sc) begin
			ncnt = 3'd0;
		end else if (dcnt_q == 3'd4) begin
			nd[0] = delay_q[1];
			nd[1] = delay_q[2];
			nd[2] = delay_q[3];
			nd[3] = data_byte;
			ncnt  = 3'd4;
		end else begin
			nd[dcnt_q[1:0]] = data_byte;
			ncnt            = dcnt_q + 3'd1;
		end

		seen_n = seen_q | sc;
		if (sc) begin
			a_n = seen_q ? pay : 3'd0;
		end else begin
			a_n = (dcnt_q == 3'd4 && seen_q) ? 3'd1 : 3'd0;
		end
		b_n = (frame_last && seen_n) ? ncnt : 3'd0;
		n   = a_n + b_n;

		batch.bytes[0] = (a_n != 3'd0) ? delay_q[0] : nd[0];
		if (a_n == 3'd2) begin
			batch.bytes[1] = delay_q[1];
		end else if (a_n == 3'd1) begin
			batch.bytes[1] = nd[0];
		end else begin
			batch.bytes[1] = nd[1];
		end
		batch.bytes[2] = (a_n == 3'd1) ? nd[1] : nd[2];
		batch.bytes[3] = (a_n == 3'd1) ? nd[2] : nd[3];
		batch.bytes[4] = nd[3];

		// all results of one transaction belong to one NALU
		first = at_start_q && (n != 3'd0);
		close = (n != 3'd0) && (sc || frame_last);
		ntype = first ? (batch.bytes[0][4:0] & annb_pkg::TYPE_MASK) : type_q;
		keep  = annb_pkg::is_kept(ntype);

		len_sum = {1'b0, len_q} + (LENGTH_BITS+1)'(n);
		if (first) begin
			len_res = LENGTH_BITS'(n);
		end else begin
			len_res = len_sum[LENGTH_BITS] ? LEN_MAX : len_sum[LENGTH_BITS-1:0];
		end

		tag_sum  = {1'b0, len_res} + (LENGTH_BITS+1)'(annb_pkg::TAG_HDR);
		tag_len  = tag_sum[LENGTH_BITS] ? LEN_MAX : tag_sum[LENGTH_BITS-1:0];
		body_sum = {1'b0, run_q} + {1'b0, tag_len};
		body_sat = body_sum[LENGTH_BITS] ? LEN_MAX : body_sum[LENGTH_BITS-1:0];
		run_n    = (close && keep) ? body_sat : run_q;

		len_ext  = 32'(len_res);
		body_ext = 32'(run_n);

		batch.count     = (n == 3'd0 && frame_last) ? 3'd1 : n;
		batch.has_bytes = (n != 3'd0);
		batch.first     = first;
		batch.close     = close;
		batch.frame     = frame_last;
		batch.no_code   = !seen_n;
		batch.keep      = keep;
		batch.ntype     = ntype;
		batch.nlen      = len_ext[annb_pkg::FIELD_W-1:0];
		batch.body      = body_ext[annb_pkg::FIELD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < annb_pkg::DELAY_DEPTH; i++) begin
				delay_q[i] <= 8'd0;
			end
			dcnt_q     <= 3'd0;
			seen_q     <= 1'b0;
			at_start_q <= 1'b0;
			type_q     <= 5'd0;
			len_q      <= '0;
			run_q      <= LENGTH_BITS'(annb_pkg::BODY_BASE);
		end else if (take) begin
			if (frame_last) begin
				// every frame starts from the reset state
				for (int i = 0; i < annb_pkg::DELAY_DEPTH; i++) begin
					delay_q[i] <= 8'd0;
				end
				dcnt_q     <= 3'd0;
				seen_q     <= 1'b0;
				at_start_q <= 1'b0;
				type_q     <= 5'd0;
				len_q      <= '0;
				run_q      <= LENGTH_BITS'(annb_pkg::BODY_BASE);
			end else begin
				delay_q    <= nd;
				dcnt_q     <= ncnt;
				seen_q     <= seen_n;
				at_start_q <= sc ? 1'b1 : (first ? 1'b0 : at_start_q);
				type_q     <= (n != 3'd0) ? ntype : type_q;
				if (close) begin
					len_q <= '0;
				end else if (n != 3'd0) begin
					len_q <= len_res;
				end
				run_q <= run_n;
			end
		end
	end

endmodule

@@ rtl/annexb_nalu_splitter.sv @@
// Latency: first result of a transaction is valid the cycle after the byte is accepted.
// Throughput while nalu_stream is ready: one byte per cycle while each byte yields at
// most one result; a byte completing a start code or ending the frame yields up to five
// results, drained one per cycle from the result register; new bytes wait for the last one.
// Reset: arst_n clears the parser to frame-start state and empties the result register.
module annexb_nalu_splitter #(
	parameter int LENGTH_BITS = annb_pkg::LENGTH_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	annb_byte_if.sink   byte_stream,
	annb_nalu_if.source nalu_stream
);

	annb_pkg::batch_t batch;
	annb_pkg::batch_t batch_q;
	logic [2:0]       occ_q;
	logic [2:0]       head_q;
	logic             take;
	logic             pop;
	logic             last_idx;
	logic             bv;
	logic             nalu_end;
	logic             frame_end;

	assign last_idx          = (head_q == occ_q - 3'd1);
	assign byte_stream.ready = (occ_q == 3'd0) || (nalu_stream.ready && last_idx);
	assign take              = byte_stream.valid && byte_stream.ready;
	assign pop               = nalu_stream.valid && nalu_stream.ready;

	annb_parse #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (byte_stream.data_byte),
		.frame_last (byte_stream.frame_last),
		.batch      (batch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= 3'd0;
			head_q <= 3'd0;
		end else if (take && batch.count != 3'd0) begin
			occ_q  <= batch.count;
			head_q <= 3'd0;
		end else if (pop) begin
			if (last_idx) begin
				occ_q  <= 3'd0;
				head_q <= 3'd0;
			end else begin
				head_q <= head_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && batch.count != 3'd0) begin
			batch_q <= batch;
		end
	end

	assign bv        = batch_q.has_bytes;
	assign nalu_end  = bv && last_idx && batch_q.close;
	assign frame_end = last_idx && batch_q.frame;

	assign nalu_stream.valid         = (occ_q != 3'd0);
	assign nalu_stream.out_byte      = bv ? batch_q.bytes[head_q] : 8'd0;
	assign nalu_stream.byte_valid    = bv;
	assign nalu_stream.unit_type     = bv ? batch_q.ntype : 5'd0;
	assign nalu_stream.nalu_first    = bv && (head_q == 3'd0) && batch_q.first;
	assign nalu_stream.nalu_last     = nalu_end;
	assign nalu_stream.nalu_keep     = bv && batch_q.keep;
	assign nalu_stream.nalu_length   = nalu_end ? batch_q.nlen : '0;
	assign nalu_stream.frame_done    = frame_end;
	assign nalu_stream.body_length   = frame_end ? batch_q.body : '0;
	assign nalu_stream.no_start_code = frame_end && batch_q.no_code;
	assign nalu_stream.run_last      = last_idx;

endmodule
